### src/lpd_pkg.sv
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared types and constants of the length-prefixed message deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package lpd_pkg;

    // Width of the saturating segment counter
    localparam int unsigned SEG_CNT_BITS = 12;
    localparam logic [SEG_CNT_BITS-1:0] SEG_CNT_MAX = {SEG_CNT_BITS{1'b1}};

    // Fixed widths of the result fields
    localparam int unsigned BYTE_BITS = 8;
    localparam int unsigned LEN_BITS  = 32;
    localparam int unsigned NUM_BITS  = 12;

    // Byte classification codes
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_TYPE    = 2'd0;
    localparam t_kind KIND_BODYLEN = 2'd1;
    localparam t_kind KIND_SEGLEN  = 2'd2;
    localparam t_kind KIND_DATA    = 2'd3;

    // Parser phases
    typedef logic [1:0] t_phase;
    localparam t_phase PH_TYPE    = 2'd0;
    localparam t_phase PH_BODYLEN = 2'd1;
    localparam t_phase PH_SEGLEN  = 2'd2;
    localparam t_phase PH_DATA    = 2'd3;

    // Header byte index within a 4-byte length field
    localparam logic [1:0] HDR_LAST = 2'd3;

    // One classified word
    typedef struct packed {
        logic [BYTE_BITS-1:0] echo_byte;
        t_kind                byte_kind;
        logic [BYTE_BITS-1:0] message_type;
        logic [NUM_BITS-1:0]  segment_number;
        logic                 segment_done;
        logic                 message_done;
        logic [NUM_BITS-1:0]  segment_total;
        logic                 overrun;
    } t_result;

endpackage

`default_nettype wire

### src/lpd_parser.sv
// ----------------------------------------------------------------------------
// lpd_parser
// Message framing state and combinational classification of one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module lpd_parser (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_advance,
    input  wire logic [lpd_pkg::BYTE_BITS-1:0] i_byte,
    output lpd_pkg::t_result                  o_result
);

    lpd_pkg::t_phase                      r_phase,  n_phase;
    logic [1:0]                           r_hdr,    n_hdr;
    logic [lpd_pkg::LEN_BITS-1:0]         r_body,   n_body;
    logic [lpd_pkg::LEN_BITS-1:0]         r_seg,    n_seg;
    logic [lpd_pkg::BYTE_BITS-1:0]        r_type,   n_type;
    logic [lpd_pkg::SEG_CNT_BITS-1:0]     r_cnt,    n_cnt;
    logic                                 r_ovr,    n_ovr;

    logic [lpd_pkg::SEG_CNT_BITS-1:0]     cnt_inc;
    logic [lpd_pkg::LEN_BITS-1:0]         body_dec;
    logic [lpd_pkg::LEN_BITS-1:0]         seg_dec;
    logic [lpd_pkg::LEN_BITS-1:0]         body_shift;
    logic [lpd_pkg::LEN_BITS-1:0]         seg_shift;
    logic                                 body_last;
    logic                                 seg_last;
    lpd_pkg::t_kind                       kind;
    logic                                 use_index;
    logic                                 seg_done;
    logic                                 msg_done;
    logic [lpd_pkg::SEG_CNT_BITS+lpd_pkg::NUM_BITS-1:0] cur_ext;
    logic [lpd_pkg::SEG_CNT_BITS+lpd_pkg::NUM_BITS-1:0] tot_ext;

    assign cnt_inc    = (r_cnt != lpd_pkg::SEG_CNT_MAX) ? r_cnt + 1'b1 : r_cnt;
    assign body_dec   = r_body - 1'b1;
    assign seg_dec    = r_seg - 1'b1;
    assign body_shift = {r_body[lpd_pkg::LEN_BITS-9:0], i_byte};
    assign seg_shift  = {r_seg[lpd_pkg::LEN_BITS-9:0], i_byte};
    // this word uses up the last body byte
    assign body_last  = (r_body == {{(lpd_pkg::LEN_BITS-1){1'b0}}, 1'b1});
    assign seg_last   = (r_seg == {{(lpd_pkg::LEN_BITS-1){1'b0}}, 1'b1});

    always_comb begin
        n_phase   = r_phase;
        n_hdr     = r_hdr;
        n_body    = r_body;
        n_seg     = r_seg;
        n_type    = r_type;
        n_cnt     = r_cnt;
        n_ovr     = r_ovr;
        kind      = lpd_pkg::KIND_DATA;
        use_index = 1'b0;
        seg_done  = 1'b0;
        msg_done  = 1'b0;
        case (r_phase)
            lpd_pkg::PH_TYPE: begin
                kind    = lpd_pkg::KIND_TYPE;
                n_type  = i_byte;
                n_cnt   = '0;
                n_ovr   = 1'b0;
                n_body  = '0;
                n_seg   = '0;
                n_hdr   = '0;
                n_phase = lpd_pkg::PH_BODYLEN;
            end
            lpd_pkg::PH_BODYLEN: begin
                kind   = lpd_pkg::KIND_BODYLEN;
                n_body = body_shift;
                if (r_hdr == lpd_pkg::HDR_LAST) begin
                    n_hdr = '0;
                    if (body_shift == '0) begin
                        msg_done = 1'b1;
                        n_phase  = lpd_pkg::PH_TYPE;
                    end else begin
                        n_seg   = '0;
                        n_phase = lpd_pkg::PH_SEGLEN;
                    end
                end else begin
                    n_hdr = r_hdr + 1'b1;
                end
            end
            lpd_pkg::PH_SEGLEN: begin
                kind      = lpd_pkg::KIND_SEGLEN;
                use_index = 1'b1;
                n_seg     = seg_shift;
                n_body    = body_dec;
                if (r_hdr != lpd_pkg::HDR_LAST) begin
                    if (body_last) begin
                        // body ends inside the length header: cut here
                        seg_done = 1'b1;
                        msg_done = 1'b1;
                        n_ovr    = 1'b1;
                        n_cnt    = cnt_inc;
                        n_hdr    = '0;
                        n_phase  = lpd_pkg::PH_TYPE;
                    end else begin
                        n_hdr = r_hdr + 1'b1;
                    end
                end else begin
                    n_hdr = '0;
                    if (seg_shift == '0) begin
                        seg_done = 1'b1;
                        n_cnt    = cnt_inc;
                        if (body_last) begin
                            msg_done = 1'b1;
                            n_phase  = lpd_pkg::PH_TYPE;
                        end
                    end else if (body_last) begin
                        seg_done = 1'b1;
                        msg_done = 1'b1;
                        n_ovr    = 1'b1;
                        n_cnt    = cnt_inc;
                        n_phase  = lpd_pkg::PH_TYPE;
                    end else begin
                        n_phase = lpd_pkg::PH_DATA;
                    end
                end
            end
            default: begin
                kind      = lpd_pkg::KIND_DATA;
                use_index = 1'b1;
                n_body    = body_dec;
                n_seg     = seg_dec;
                if (body_last) begin
                    seg_done = 1'b1;
                    msg_done = 1'b1;
                    if (!seg_last) begin
                        n_ovr = 1'b1;
                    end
                    n_cnt   = cnt_inc;
                    n_phase = lpd_pkg::PH_TYPE;
                end else if (seg_last) begin
                    seg_done = 1'b1;
                    n_cnt    = cnt_inc;
                    n_hdr    = '0;
                    n_phase  = lpd_pkg::PH_SEGLEN;
                end
            end
        endcase
    end

    assign cur_ext = {{lpd_pkg::NUM_BITS{1'b0}}, r_cnt};
    assign tot_ext = {{lpd_pkg::NUM_BITS{1'b0}}, n_cnt};

    always_comb begin
        o_result.echo_byte      = i_byte;
        o_result.byte_kind      = kind;
        o_result.message_type   = n_type;
        o_result.segment_number = use_index ? cur_ext[lpd_pkg::NUM_BITS-1:0] : '0;
        o_result.segment_done   = seg_done;
        o_result.message_done   = msg_done;
        o_result.segment_total  = tot_ext[lpd_pkg::NUM_BITS-1:0];
        o_result.overrun        = n_ovr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= lpd_pkg::PH_TYPE;
            r_hdr   <= '0;
            r_body  <= '0;
            r_seg   <= '0;
            r_type  <= '0;
            r_cnt   <= '0;
            r_ovr   <= 1'b0;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_hdr   <= n_hdr;
            r_body  <= n_body;
            r_seg   <= n_seg;
            r_type  <= n_type;
            r_cnt   <= n_cnt;
            r_ovr   <= n_ovr;
        end
    end

endmodule

`default_nettype wire

### src/lpd_result_reg.sv
// ----------------------------------------------------------------------------
// lpd_result_reg
// Output register holding one classified word until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module lpd_result_reg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire lpd_pkg::t_result i_result,
    input  wire logic             i_out_stall,
    output logic                  o_free,
    output logic                  o_out_valid,
    output lpd_pkg::t_result      o_result
);

    logic             r_valid;
    lpd_pkg::t_result r_result;

    // free when empty or when the held word leaves this cycle
    assign o_free      = !r_valid || !i_out_stall;
    assign o_out_valid = r_valid;
    assign o_result    = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

### src/length_prefixed_message_deframer.sv
// ----------------------------------------------------------------------------
// length_prefixed_message_deframer
// Splits a byte stream of type/length/segment messages and tags every byte.
//
// Input channel: i_in_valid / o_in_stall carry one stream byte per word.
// Output channel: o_out_valid / i_out_stall carry one classified word per
// input byte: the echoed byte, its kind, the latched message type, segment
// index, segment and message end flags, running segment count and overrun.
// Path: a byte accepted into the input register is classified by the parser
// logic and loaded into the result register, which offers it on the output
// from then on (input register, then result register behind the parser logic).
// Throughput: one byte per clock; every stage advances each cycle while the
// output is not stalled, and a stage frees as soon as its word moves on.
// A stall on the output holds the result word and then the input register;
// o_in_stall rises only when both are full.
// Reset (synchronous, active low) empties both registers and returns the
// parser to expect a type byte with all counts cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefixed_message_deframer (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [lpd_pkg::BYTE_BITS-1:0] i_stream_byte,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [lpd_pkg::BYTE_BITS-1:0]      o_echo_byte,
    output logic [1:0]                         o_byte_kind,
    output logic [lpd_pkg::BYTE_BITS-1:0]      o_message_type,
    output logic [lpd_pkg::NUM_BITS-1:0]       o_segment_number,
    output logic                               o_segment_done,
    output logic                               o_message_done,
    output logic [lpd_pkg::NUM_BITS-1:0]       o_segment_total,
    output logic                               o_overrun
);

    logic                          r_in_valid;
    logic [lpd_pkg::BYTE_BITS-1:0] r_in_byte;
    logic                          out_free;
    logic                          advance;
    logic                          in_take;
    lpd_pkg::t_result              parse_res;
    lpd_pkg::t_result              out_res;

    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_stream_byte;
        end
    end

    lpd_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_byte    (r_in_byte),
        .o_result  (parse_res)
    );

    lpd_result_reg u_result (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (r_in_valid),
        .i_result    (parse_res),
        .i_out_stall (i_out_stall),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .o_result    (out_res)
    );

    assign o_echo_byte      = out_res.echo_byte;
    assign o_byte_kind      = out_res.byte_kind;
    assign o_message_type   = out_res.message_type;
    assign o_segment_number = out_res.segment_number;
    assign o_segment_done   = out_res.segment_done;
    assign o_message_done   = out_res.message_done;
    assign o_segment_total  = out_res.segment_total;
    assign o_overrun        = out_res.overrun;

endmodule

`default_nettype wire

### sim/lpd_checker.sv
// ----------------------------------------------------------------------------
// lpd_checker
// Watches both channels of the deframer, predicts the classified word for
// every accepted stream byte and compares each output word against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpd_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic                          i_in_stall,
    input  wire logic [lpd_pkg::BYTE_BITS-1:0] i_stream_byte,
    input  wire logic                          i_out_valid,
    input  wire logic                          i_out_stall,
    input  wire logic [lpd_pkg::BYTE_BITS-1:0] i_echo_byte,
    input  wire logic [1:0]                    i_byte_kind,
    input  wire logic [lpd_pkg::BYTE_BITS-1:0] i_message_type,
    input  wire logic [lpd_pkg::NUM_BITS-1:0]  i_segment_number,
    input  wire logic                          i_segment_done,
    input  wire logic                          i_message_done,
    input  wire logic [lpd_pkg::NUM_BITS-1:0]  i_segment_total,
    input  wire logic                          i_overrun,
    output int                                 o_errors,
    output int                                 o_pending,
    output int                                 o_words,
    output int                                 o_messages,
    output int                                 o_overrun_msgs
);

    // Shadow parser state
    lpd_pkg::t_phase                  parse_phase;
    logic [1:0]                       hdr_idx;
    logic [lpd_pkg::LEN_BITS-1:0]     body_left;
    logic [lpd_pkg::LEN_BITS-1:0]     seg_left;
    logic [lpd_pkg::BYTE_BITS-1:0]    msg_type;
    logic [lpd_pkg::SEG_CNT_BITS-1:0] seg_count;
    logic                             overrun_flag;

    lpd_pkg::t_result expected_words[$];

    initial begin
        o_errors       = 0;
        o_pending      = 0;
        o_words        = 0;
        o_messages     = 0;
        o_overrun_msgs = 0;
    end

    function automatic void bump_segments();
        if (seg_count != lpd_pkg::SEG_CNT_MAX) seg_count++;
    endfunction

    function automatic lpd_pkg::t_result classify_byte(
        input logic [lpd_pkg::BYTE_BITS-1:0] b
    );
        lpd_pkg::t_result r;
        r = '0;
        r.echo_byte = b;
        case (parse_phase)
            lpd_pkg::PH_TYPE: begin
                r.byte_kind  = lpd_pkg::KIND_TYPE;
                msg_type     = b;
                seg_count    = '0;
                overrun_flag = 1'b0;
                body_left    = '0;
                seg_left     = '0;
                hdr_idx      = '0;
                parse_phase  = lpd_pkg::PH_BODYLEN;
            end
            lpd_pkg::PH_BODYLEN: begin
                r.byte_kind = lpd_pkg::KIND_BODYLEN;
                body_left   = {body_left[lpd_pkg::LEN_BITS-9:0], b};
                if (hdr_idx == lpd_pkg::HDR_LAST) begin
                    hdr_idx = '0;
                    if (body_left == '0) begin
                        r.message_done = 1'b1;
                        parse_phase    = lpd_pkg::PH_TYPE;
                    end else begin
                        seg_left    = '0;
                        parse_phase = lpd_pkg::PH_SEGLEN;
                    end
                end else begin
                    hdr_idx++;
                end
            end
            lpd_pkg::PH_SEGLEN: begin
                r.byte_kind      = lpd_pkg::KIND_SEGLEN;
                r.segment_number = seg_count;
                seg_left         = {seg_left[lpd_pkg::LEN_BITS-9:0], b};
                body_left--;
                if (hdr_idx != lpd_pkg::HDR_LAST) begin
                    // body ends inside the segment header
                    if (body_left == '0) begin
                        r.segment_done = 1'b1;
                        r.message_done = 1'b1;
                        overrun_flag   = 1'b1;
                        bump_segments();
                        hdr_idx        = '0;
                        parse_phase    = lpd_pkg::PH_TYPE;
                    end else begin
                        hdr_idx++;
                    end
                end else begin
                    hdr_idx = '0;
                    if (seg_left == '0) begin
                        r.segment_done = 1'b1;
                        bump_segments();
                        if (body_left == '0) begin
                            r.message_done = 1'b1;
                            parse_phase    = lpd_pkg::PH_TYPE;
                        end else begin
                            parse_phase = lpd_pkg::PH_SEGLEN;
                        end
                    end else if (body_left == '0) begin
                        r.segment_done = 1'b1;
                        r.message_done = 1'b1;
                        overrun_flag   = 1'b1;
                        bump_segments();
                        parse_phase    = lpd_pkg::PH_TYPE;
                    end else begin
                        parse_phase = lpd_pkg::PH_DATA;
                    end
                end
            end
            default: begin
                r.byte_kind      = lpd_pkg::KIND_DATA;
                r.segment_number = seg_count;
                body_left--;
                seg_left--;
                if (body_left == '0) begin
                    // cut the segment at message end
                    r.segment_done = 1'b1;
                    r.message_done = 1'b1;
                    if (seg_left != '0) overrun_flag = 1'b1;
                    bump_segments();
                    parse_phase = lpd_pkg::PH_TYPE;
                end else if (seg_left == '0) begin
                    r.segment_done = 1'b1;
                    bump_segments();
                    hdr_idx     = '0;
                    parse_phase = lpd_pkg::PH_SEGLEN;
                end
            end
        endcase
        r.message_type  = msg_type;
        r.segment_total = seg_count;
        r.overrun       = overrun_flag;
        return r;
    endfunction

    always @(posedge i_clk) begin
        lpd_pkg::t_result got;
        lpd_pkg::t_result want;
        if (!i_rst_n) begin
            parse_phase  = lpd_pkg::PH_TYPE;
            hdr_idx      = '0;
            body_left    = '0;
            seg_left     = '0;
            msg_type     = '0;
            seg_count    = '0;
            overrun_flag = 1'b0;
            expected_words.delete();
            o_pending = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = {i_echo_byte, i_byte_kind, i_message_type, i_segment_number,
                       i_segment_done, i_message_done, i_segment_total, i_overrun};
                o_words++;
                if (expected_words.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("%0t: word with nothing expected: byte %02h kind %0d",
                                 $realtime, got.echo_byte, got.byte_kind);
                end else begin
                    want = expected_words.pop_front();
                    if (got !== want) begin
                        o_errors++;
                        if (o_errors <= 10) begin
                            $display("%0t: mismatch on word %0d", $realtime, o_words);
                            $display({"  exp byte %02h kind %0d type %02h seg %0d",
                                      " sdone %0b mdone %0b total %0d ovr %0b"},
                                     want.echo_byte, want.byte_kind, want.message_type,
                                     want.segment_number, want.segment_done,
                                     want.message_done, want.segment_total, want.overrun);
                            $display({"  got byte %02h kind %0d type %02h seg %0d",
                                      " sdone %0b mdone %0b total %0d ovr %0b"},
                                     got.echo_byte, got.byte_kind, got.message_type,
                                     got.segment_number, got.segment_done,
                                     got.message_done, got.segment_total, got.overrun);
                        end
                    end
                    if (want.message_done) begin
                        o_messages++;
                        if (want.overrun) o_overrun_msgs++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_words.push_back(classify_byte(i_stream_byte));
            o_pending = expected_words.size();
        end
    end

endmodule

`default_nettype wire

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the deframer with framed byte streams and reports the verdict.
// Directed edge cases come first, then random messages (well formed, cut
// short and noisy) and a trailing message that never ends. Both channels
// idle at random and the output is held off once for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module testbench;

    localparam int RANDOM_BYTES    = 1850;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int PRESSURE_AT     = 300;
    localparam int PRESSURE_CYCLES = 250;

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          i_in_valid    = 1'b0;
    logic [lpd_pkg::BYTE_BITS-1:0] i_stream_byte = '0;
    logic                          i_out_stall   = 1'b0;
    logic                          o_in_stall;
    logic                          o_out_valid;
    logic [lpd_pkg::BYTE_BITS-1:0] o_echo_byte;
    logic [1:0]                    o_byte_kind;
    logic [lpd_pkg::BYTE_BITS-1:0] o_message_type;
    logic [lpd_pkg::NUM_BITS-1:0]  o_segment_number;
    logic                          o_segment_done;
    logic                          o_message_done;
    logic [lpd_pkg::NUM_BITS-1:0]  o_segment_total;
    logic                          o_overrun;

    int errors, pending, words, messages, overrun_msgs;

    logic [lpd_pkg::BYTE_BITS-1:0] stream_bytes[$];
    int  stream_len   = 0;
    bit  stream_ready = 1'b0;
    int  sent         = 0;
    int  send_pos     = 0;
    int  burst_left   = 0;
    int  gap_left     = 0;
    int  cycles       = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    length_prefixed_message_deframer dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_stream_byte    (i_stream_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_echo_byte      (o_echo_byte),
        .o_byte_kind      (o_byte_kind),
        .o_message_type   (o_message_type),
        .o_segment_number (o_segment_number),
        .o_segment_done   (o_segment_done),
        .o_message_done   (o_message_done),
        .o_segment_total  (o_segment_total),
        .o_overrun        (o_overrun)
    );

    lpd_checker u_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_stream_byte    (i_stream_byte),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_echo_byte      (o_echo_byte),
        .i_byte_kind      (o_byte_kind),
        .i_message_type   (o_message_type),
        .i_segment_number (o_segment_number),
        .i_segment_done   (o_segment_done),
        .i_message_done   (o_message_done),
        .i_segment_total  (o_segment_total),
        .i_overrun        (o_overrun),
        .o_errors         (errors),
        .o_pending        (pending),
        .o_words          (words),
        .o_messages       (messages),
        .o_overrun_msgs   (overrun_msgs)
    );

    task automatic put_len(input logic [lpd_pkg::LEN_BITS-1:0] v);
        for (int k = 3; k >= 0; k--) stream_bytes.push_back(v[8*k +: 8]);
    endtask

    // One random message: mostly well formed, some cut short, some noise
    task automatic put_random_message();
        logic [lpd_pkg::BYTE_BITS-1:0] body[$];
        logic [lpd_pkg::LEN_BITS-1:0]  body_len;
        int                            pick;
        int                            nseg;
        int                            seg_len;
        pick = $urandom_range(0, 99);
        if (pick < 85) begin
            nseg = $urandom_range(0, 4);
            for (int s = 0; s < nseg; s++) begin
                seg_len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40)
                                                      : $urandom_range(0, 6);
                for (int k = 3; k >= 0; k--) body.push_back(8'(seg_len >> (8 * k)));
                for (int d = 0; d < seg_len; d++) body.push_back(8'($urandom_range(0, 255)));
            end
            body_len = body.size();
            // truncate: the body ends inside a header or a segment
            if (pick >= 70 && body_len > 1) body_len = $urandom_range(1, body_len - 1);
        end else begin
            body_len = $urandom_range(1, 12);
            for (int d = 0; d < body_len; d++) body.push_back(8'($urandom_range(0, 255)));
        end
        stream_bytes.push_back(8'($urandom_range(0, 255)));
        put_len(body_len);
        for (int d = 0; d < body_len; d++) stream_bytes.push_back(body[d]);
    endtask

    // Sender: bursts of random length separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n || !stream_ready) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) sent <= sent + 1;
            if (i_in_valid && o_in_stall) begin
                // hold the stalled word
            end else if (gap_left > 0) begin
                i_in_valid <= 1'b0;
                gap_left--;
            end else if (send_pos < stream_len) begin
                i_in_valid    <= 1'b1;
                i_stream_byte <= stream_bytes[send_pos];
                send_pos++;
                if (burst_left > 1) begin
                    burst_left--;
                end else if ($urandom_range(0, 9) < 2) begin
                    burst_left = $urandom_range(150, 400);
                    gap_left   = 0;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = $urandom_range(0, 5);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern changes mode now and then; one long hold-off
    int rx_cycle  = 0;
    int rx_mode   = 0;
    int mode_left = 0;
    int hold_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            rx_cycle++;
            if (mode_left == 0) begin
                rx_mode   = $urandom_range(0, 4);
                mode_left = $urandom_range(50, 400);
            end else begin
                mode_left--;
            end
            if (rx_cycle == PRESSURE_AT) hold_left = PRESSURE_CYCLES;
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                case (rx_mode)
                    0:       i_out_stall <= 1'b0;
                    1:       i_out_stall <= ($urandom_range(0, 2) == 0);
                    2:       i_out_stall <= $urandom_range(0, 1);
                    3:       i_out_stall <= (rx_cycle % 4 == 0);
                    default: i_out_stall <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d of %0d bytes sent, %0d words pending",
                     cycles, sent, stream_len, pending);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int random_start;

        // zero body length
        stream_bytes.push_back(8'h00);
        put_len(32'h0000_0000);
        // a single empty segment
        stream_bytes.push_back(8'hFF);
        put_len(32'h0000_0004);
        put_len(32'h0000_0000);
        // body ends inside the segment header
        stream_bytes.push_back(8'h5A);
        put_len(32'h0000_0002);
        stream_bytes.push_back(8'hFF);
        stream_bytes.push_back(8'hFF);
        // segment length reaches past the body
        stream_bytes.push_back(8'h80);
        put_len(32'h0000_0006);
        put_len(32'hFFFF_FFFF);
        stream_bytes.push_back(8'hAA);
        stream_bytes.push_back(8'h55);

        random_start = stream_bytes.size();
        while (stream_bytes.size() - random_start < RANDOM_BYTES) put_random_message();

        // largest body length; the stream ends inside this message
        stream_bytes.push_back(8'h7E);
        put_len(32'hFFFF_FFFF);
        for (int d = 0; d < 8; d++) stream_bytes.push_back(8'($urandom_range(0, 255)));

        stream_len   = stream_bytes.size();
        stream_ready = 1'b1;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (sent == stream_len);
        @(posedge i_clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d stream bytes: %0d words checked, %0d messages (%0d overrun)",
                 stream_len, words, messages, overrun_msgs);
        $display("Included edge framings, cut-short bodies and a long output hold-off");
        if (errors == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches, %0d words outstanding", errors, pending);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
